### rtl/krca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krca_pkg;

  localparam int unsigned KRCA_TABLE_ENTRIES = 256;

  localparam int unsigned TS_W  = 63;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned CAP_W = 17;
  localparam int unsigned SUM_W = 40;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_OTHER  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic emit;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/krca_evt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface krca_evt_if;
  import krca_pkg::*;

  logic               valid;
  logic               ready;
  logic [TS_W-1:0]    timestamp;
  logic [KEY_W-1:0]   host_id;
  logic [1:0]         mode;
  logic [CAP_W-1:0]   cpu_capacity;
  logic [CAP_W-1:0]   mem_capacity;

  modport source (
    output valid, timestamp, host_id, mode, cpu_capacity, mem_capacity,
    input  ready
  );

  modport sink (
    input  valid, timestamp, host_id, mode, cpu_capacity, mem_capacity,
    output ready
  );

endinterface

`default_nettype wire

### rtl/krca_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface krca_res_if;
  import krca_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TS_W-1:0]         out_timestamp;
  logic signed [SUM_W-1:0] cpu_total;
  logic signed [SUM_W-1:0] mem_total;
  logic                    table_full;

  modport source (
    output valid, out_timestamp, cpu_total, mem_total, table_full,
    input  ready
  );

  modport sink (
    input  valid, out_timestamp, cpu_total, mem_total, table_full,
    output ready
  );

endinterface

`default_nettype wire

### rtl/krca_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module krca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  krca_pkg::sts_t sts_i,
  output krca_pkg::cmd_t cmd_o
);
  import krca_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last entry read is compared here
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!sts_i.emit || !sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/krca_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module krca_dp #(
  parameter int unsigned TABLE_ENTRIES = krca_pkg::KRCA_TABLE_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  krca_pkg::cmd_t                    cmd_i,
  output krca_pkg::sts_t                    sts_o,
  input  logic [krca_pkg::TS_W-1:0]         ts_i,
  input  logic [krca_pkg::KEY_W-1:0]        key_i,
  input  krca_pkg::mode_e                   mode_i,
  input  logic [krca_pkg::CAP_W-1:0]        cpu_i,
  input  logic [krca_pkg::CAP_W-1:0]        mem_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [krca_pkg::TS_W-1:0]         out_ts_o,
  output logic signed [krca_pkg::SUM_W-1:0] cpu_total_o,
  output logic signed [krca_pkg::SUM_W-1:0] mem_total_o,
  output logic                              table_full_o
);
  import krca_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned EXTW = SUM_W + 2;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic signed [EXTW-1:0] SAT_HI = {3'b000, {(SUM_W-1){1'b1}}};
  localparam logic signed [EXTW-1:0] SAT_LO = {3'b111, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [CAP_W-1:0] cpu;
    logic [CAP_W-1:0] mem;
  } entry_t;

  entry_t tbl_mem [TABLE_ENTRIES];
  entry_t rd_data_q;

  logic [AW-1:0]    cnt_q;
  logic [AW-1:0]    cmp_addr_q;
  logic             cmp_vld_q;

  logic [TS_W-1:0]  ts_q;
  logic [KEY_W-1:0] key_q;
  mode_e            mode_q;
  logic [CAP_W-1:0] cpu_q, mem_q;

  logic             hit_q, free_q;
  logic [AW-1:0]    hit_idx_q, free_idx_q;
  logic [CAP_W-1:0] hit_cpu_q, hit_mem_q;

  logic signed [SUM_W-1:0] cpu_sum_q, mem_sum_q;
  logic                    out_vld_q;
  logic [TS_W-1:0]         out_ts_q;
  logic                    out_full_q;

  logic                    is_add, is_rem, is_upd, emit;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  entry_t                  wr_data;
  logic [CAP_W-1:0]        cpu_pos, cpu_neg, mem_pos, mem_neg;
  logic signed [SUM_W-1:0] cpu_sum_d, mem_sum_d;

  function automatic logic signed [SUM_W-1:0] sat_sum(
    input logic signed [SUM_W-1:0] total,
    input logic [CAP_W-1:0]        pos,
    input logic [CAP_W-1:0]        neg
  );
    logic signed [EXTW-1:0] raw;
    raw = EXTW'(total) + $signed(EXTW'(pos)) - $signed(EXTW'(neg));
    if (raw > SAT_HI) begin
      return SAT_HI[SUM_W-1:0];
    end else if (raw < SAT_LO) begin
      return SAT_LO[SUM_W-1:0];
    end
    return raw[SUM_W-1:0];
  endfunction

  assign is_add = (mode_q == MODE_ADD);
  assign is_rem = (mode_q == MODE_REMOVE);
  assign is_upd = (mode_q == MODE_UPDATE);
  // remove or update of an unknown key gives no result
  assign emit   = !((is_rem || is_upd) && !hit_q);

  always_comb begin
    cpu_pos = '0;
    cpu_neg = '0;
    mem_pos = '0;
    mem_neg = '0;
    case (mode_q)
      MODE_ADD: begin
        cpu_pos = cpu_q;
        mem_pos = mem_q;
      end
      MODE_REMOVE: begin
        cpu_neg = cpu_q;
        mem_neg = mem_q;
      end
      MODE_UPDATE: begin
        cpu_pos = cpu_q;
        mem_pos = mem_q;
        cpu_neg = hit_cpu_q;
        mem_neg = hit_mem_q;
      end
      default: begin
      end
    endcase
  end

  assign cpu_sum_d = sat_sum(cpu_sum_q, cpu_pos, cpu_neg);
  assign mem_sum_d = sat_sum(mem_sum_q, mem_pos, mem_neg);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_q ? hit_idx_q : free_idx_q;
    wr_data = '{vld: !is_rem, key: key_q, cpu: cpu_q, mem: mem_q};
    if (cmd_i.clr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = '0;
    end else if (cmd_i.commit) begin
      wr_en = is_add ? (hit_q || free_q) : ((is_rem || is_upd) && hit_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= tbl_mem[cnt_q];
    end
  end

  // scan and clear address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_addr_q <= '0;
    end else begin
      cmp_vld_q  <= cmd_i.rd;
      cmp_addr_q <= cnt_q;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.rd || cmd_i.clr) begin
        cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ts_q   <= ts_i;
      key_q  <= key_i;
      mode_q <= mode_i;
      cpu_q  <= cpu_i;
      mem_q  <= mem_i;
    end
  end

  // lowest matching entry and lowest free entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmp_vld_q) begin
      if (rd_data_q.vld && rd_data_q.key == key_q && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (!rd_data_q.vld && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_vld_q && rd_data_q.vld && rd_data_q.key == key_q && !hit_q) begin
      hit_idx_q <= cmp_addr_q;
      hit_cpu_q <= rd_data_q.cpu;
      hit_mem_q <= rd_data_q.mem;
    end
    if (cmp_vld_q && !rd_data_q.vld && !free_q) begin
      free_idx_q <= cmp_addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_sum_q <= '0;
      mem_sum_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.commit && emit) begin
        cpu_sum_q <= cpu_sum_d;
        mem_sum_q <= mem_sum_d;
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && emit) begin
      out_ts_q   <= ts_q;
      out_full_q <= is_add && !hit_q && !free_q;
    end
  end

  assign sts_o.cnt_last = (cnt_q == LAST_IDX);
  assign sts_o.emit     = emit;
  assign sts_o.out_busy = out_vld_q && !out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_ts_o     = out_ts_q;
  assign cpu_total_o  = cpu_sum_q;
  assign mem_total_o  = mem_sum_q;
  assign table_full_o = out_full_q;

endmodule

`default_nettype wire

### rtl/keyed_resource_capacity_accounting.sv
`timescale 1ns / 1ps
`default_nettype none

// Machine capacity accounting: keeps a table of TABLE_ENTRIES machine ids with
// their cpu and memory capacities and two saturating 40-bit running totals, and
// returns the event timestamp with both totals for each add, other, or
// remove/update of a known id. Events are handled one at a time. From accept to
// result, the entry memory, which has a single read port, is scanned one entry
// per cycle to find the id and the lowest free entry, a drain step then compares
// the last entry read, and a commit step writes the entry back and loads the
// result register. The next event is taken while a result still waits in the
// output register; its write back then waits until that result is accepted if
// it gives a result of its own. After reset a clearing pass writes every entry
// empty before the first event is accepted.
module keyed_resource_capacity_accounting #(
  parameter int unsigned TABLE_ENTRIES = krca_pkg::KRCA_TABLE_ENTRIES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  krca_evt_if.sink   evt_i,
  krca_res_if.source res_o
);
  import krca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  krca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_ready_o (evt_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  krca_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ts_i         (evt_i.timestamp),
    .key_i        (evt_i.host_id),
    .mode_i       (mode_e'(evt_i.mode)),
    .cpu_i        (evt_i.cpu_capacity),
    .mem_i        (evt_i.mem_capacity),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_ts_o     (res_o.out_timestamp),
    .cpu_total_o  (res_o.cpu_total),
    .mem_total_o  (res_o.mem_total),
    .table_full_o (res_o.table_full)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.load, cmd.rd, cmd.commit}))
    else $error("more than one datapath command at once");

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd || cmd.clr) |-> !evt_i.ready)
    else $error("item accepted during table scan or clear");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd.commit))
    else $error("result shown without a commit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(sts.emit && sts.out_busy))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### verif/keyed_resource_capacity_accounting_tb.sv
`timescale 1ns / 1ps

module keyed_resource_capacity_accounting_tb;
  import krca_pkg::*;

  localparam int TBL         = KRCA_TABLE_ENTRIES;
  localparam int LONG_HOLD   = 1500;
  localparam int MAX_GAP     = 2 * TBL + 6;
  localparam int STALL_LIMIT = 3 * (LONG_HOLD + MAX_GAP + TBL + 3);

  localparam logic [TS_W-1:0]  TS_MAX   = {TS_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_ALT  = {32{2'b10}};
  localparam logic [CAP_W-1:0] CAP_ONE  = 17'h10000;
  localparam logic [CAP_W-1:0] CAP_MAX  = {CAP_W{1'b1}};
  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));

  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [KEY_W-1:0] key;
    mode_e            mode;
    logic [CAP_W-1:0] cpu;
    logic [CAP_W-1:0] mem;
  } machine_event_t;

  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [SUM_W-1:0] cpu_total;
    logic [SUM_W-1:0] mem_total;
    logic             full;
  } totals_t;

  logic clk_i;
  logic rst_ni;

  krca_evt_if evt_bus ();
  krca_res_if res_bus ();

  keyed_resource_capacity_accounting u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_bus),
    .res_o  (res_bus)
  );

  // machine table and totals as the block should hold them
  bit               tab_valid [TBL];
  logic [KEY_W-1:0] tab_key   [TBL];
  logic [CAP_W-1:0] tab_cpu   [TBL];
  logic [CAP_W-1:0] tab_mem   [TBL];
  longint           cpu_acc;
  longint           mem_acc;

  totals_t pending_totals_q [$];
  int      mismatch_cnt = 0;
  int      snd_idle_pct = 21;
  int      rcv_idle_pct = 62;
  int      hold_reqs    = 0;
  int      hold_served;
  int      hold_left;
  int      idle_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_total(input longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  // returns 1 when the event produces a result
  function automatic bit account_event(input machine_event_t ev, output totals_t res);
    int hit;
    int slot;
    bit full;
    hit  = -1;
    slot = -1;
    full = 1'b0;
    for (int i = 0; i < TBL; i++) begin
      if (tab_valid[i] && tab_key[i] == ev.key) begin
        hit = i;
        break;
      end
    end
    case (ev.mode)
      MODE_ADD: begin
        cpu_acc = clamp_total(cpu_acc + longint'(ev.cpu));
        mem_acc = clamp_total(mem_acc + longint'(ev.mem));
        slot = hit;
        if (slot < 0) begin
          for (int i = 0; i < TBL; i++) begin
            if (!tab_valid[i]) begin
              slot = i;
              break;
            end
          end
        end
        if (slot < 0) begin
          full = 1'b1;
        end else begin
          tab_valid[slot] = 1'b1;
          tab_key[slot]   = ev.key;
          tab_cpu[slot]   = ev.cpu;
          tab_mem[slot]   = ev.mem;
        end
      end
      MODE_REMOVE: begin
        if (hit < 0) return 1'b0;
        // the item's own capacities come off, not the stored ones
        cpu_acc = clamp_total(cpu_acc - longint'(ev.cpu));
        mem_acc = clamp_total(mem_acc - longint'(ev.mem));
        tab_valid[hit] = 1'b0;
      end
      MODE_UPDATE: begin
        if (hit < 0) return 1'b0;
        cpu_acc = clamp_total(cpu_acc + longint'(ev.cpu) - longint'(tab_cpu[hit]));
        mem_acc = clamp_total(mem_acc + longint'(ev.mem) - longint'(tab_mem[hit]));
        tab_cpu[hit] = ev.cpu;
        tab_mem[hit] = ev.mem;
      end
      default: ;
    endcase
    res.ts        = ev.ts;
    res.cpu_total = cpu_acc[SUM_W-1:0];
    res.mem_total = mem_acc[SUM_W-1:0];
    res.full      = full;
    return 1'b1;
  endfunction

  function automatic machine_event_t build_event(input logic [TS_W-1:0] ts,
                                                 input logic [KEY_W-1:0] key,
                                                 input mode_e mode,
                                                 input logic [CAP_W-1:0] cpu,
                                                 input logic [CAP_W-1:0] mem);
    machine_event_t ev;
    ev.ts   = ts;
    ev.key  = key;
    ev.mode = mode;
    ev.cpu  = cpu;
    ev.mem  = mem;
    return ev;
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    return TS_W'({$urandom, $urandom});
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CAP_W-1:0] rand_capacity();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return CAP_ONE;
    if (r < 25) return CAP_MAX;
    if (r < 55) return CAP_W'($urandom);
    return CAP_W'($urandom_range(CAP_ONE));
  endfunction

  function automatic bit pick_known_key(output logic [KEY_W-1:0] key);
    int slots [$];
    for (int i = 0; i < TBL; i++) begin
      if (tab_valid[i]) slots = {slots, i};
    end
    if (slots.size() == 0) return 1'b0;
    key = tab_key[slots[$urandom_range(slots.size() - 1)]];
    return 1'b1;
  endfunction

  task automatic offer_event(input machine_event_t ev);
    int unsigned gap;
    totals_t res;
    gap = 0;
    if ($urandom_range(99) < snd_idle_pct) gap = $urandom_range(1, MAX_GAP);
    if (gap != 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_bus.valid        <= 1'b1;
    evt_bus.timestamp    <= ev.ts;
    evt_bus.host_id      <= ev.key;
    evt_bus.mode         <= ev.mode;
    evt_bus.cpu_capacity <= ev.cpu;
    evt_bus.mem_capacity <= ev.mem;
    do @(posedge clk_i); while (evt_bus.ready !== 1'b1);
    if (account_event(ev, res)) pending_totals_q = {pending_totals_q, res};
  endtask

  task automatic test_directed_modes();
    offer_event(build_event('0, '0, MODE_OTHER, '0, '0));
    // remove and update of an unknown id give nothing back
    offer_event(build_event(TS_MAX, KEY_ONES, MODE_REMOVE, CAP_ONE, CAP_ONE));
    offer_event(build_event(rand_ts(), KEY_ONES, MODE_UPDATE, CAP_ONE, CAP_ONE));
    offer_event(build_event(TS_MAX, KEY_ONES, MODE_ADD, CAP_ONE, CAP_ONE));
    offer_event(build_event(rand_ts(), '0, MODE_ADD, CAP_MAX, '0));
    // add on a known id overwrites without taking the old values off
    offer_event(build_event(rand_ts(), KEY_ONES, MODE_ADD, 17'd1, CAP_MAX));
    offer_event(build_event(rand_ts(), KEY_ONES, MODE_UPDATE, '0, '0));
    offer_event(build_event(rand_ts(), '0, MODE_UPDATE, CAP_ONE, CAP_ONE));
    offer_event(build_event(rand_ts(), '0, MODE_REMOVE, 17'd5, 17'd7));
    offer_event(build_event(rand_ts(), '0, MODE_REMOVE, 17'd5, 17'd7));
    offer_event(build_event(rand_ts(), KEY_ALT, MODE_ADD, 17'h15555, 17'h0aaaa));
    offer_event(build_event(rand_ts(), ~KEY_ALT, MODE_ADD, 17'h0aaaa, 17'h15555));
    offer_event(build_event(rand_ts(), KEY_ALT, MODE_OTHER, CAP_MAX, CAP_MAX));
    offer_event(build_event(rand_ts(), KEY_ALT ^ 64'h1, MODE_UPDATE, CAP_MAX, CAP_MAX));
    // removes with more than was added push the totals below zero
    offer_event(build_event(rand_ts(), KEY_ONES, MODE_REMOVE, CAP_MAX, CAP_MAX));
    offer_event(build_event(rand_ts(), ~KEY_ALT, MODE_REMOVE, CAP_MAX, CAP_MAX));
    offer_event(build_event(rand_ts(), KEY_ALT, MODE_REMOVE, CAP_MAX, CAP_MAX));
    offer_event(build_event(rand_ts(), '0, MODE_ADD, '0, '0));
  endtask

  task automatic test_table_full();
    int n_free;
    logic [KEY_W-1:0] known;
    n_free = 0;
    for (int i = 0; i < TBL; i++) begin
      if (!tab_valid[i]) n_free++;
    end
    repeat (n_free + 3)
      offer_event(build_event(rand_ts(), rand_key(), MODE_ADD, rand_capacity(),
                              rand_capacity()));
    void'(pick_known_key(known));
    offer_event(build_event(rand_ts(), known, MODE_ADD, rand_capacity(), rand_capacity()));
    offer_event(build_event(rand_ts(), known, MODE_UPDATE, rand_capacity(), rand_capacity()));
    offer_event(build_event(rand_ts(), rand_key(), MODE_REMOVE, CAP_ONE, CAP_ONE));
    offer_event(build_event(rand_ts(), rand_key(), MODE_OTHER, CAP_MAX, '0));
    // free a middle entry, refill it, then overflow again
    offer_event(build_event(rand_ts(), tab_key[TBL/2], MODE_REMOVE, rand_capacity(),
                            rand_capacity()));
    offer_event(build_event(rand_ts(), rand_key(), MODE_ADD, rand_capacity(), rand_capacity()));
    offer_event(build_event(rand_ts(), rand_key(), MODE_ADD, rand_capacity(), rand_capacity()));
  endtask

  task automatic test_table_drain();
    for (int i = 0; i < TBL; i++) begin
      if (tab_valid[i])
        offer_event(build_event(rand_ts(), tab_key[i], MODE_REMOVE, rand_capacity(),
                                rand_capacity()));
    end
  endtask

  task automatic test_random_mix(input int n, input int snd_pct, input int rcv_pct);
    machine_event_t ev;
    int unsigned r;
    logic [KEY_W-1:0] known;
    bit have;
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
    repeat (n) begin
      r = $urandom_range(99);
      have = pick_known_key(known);
      ev = build_event(rand_ts(), rand_key(), MODE_OTHER, rand_capacity(), rand_capacity());
      if (r < 40) begin
        ev.mode = MODE_ADD;
        if (have && $urandom_range(99) < 25) ev.key = known;
      end else if (r < 65) begin
        ev.mode = MODE_REMOVE;
        if (have && $urandom_range(99) < 85) ev.key = known;
      end else if (r < 90) begin
        ev.mode = MODE_UPDATE;
        if (have && $urandom_range(99) < 85) ev.key = known;
      end
      offer_event(ev);
    end
  endtask

  // result side holds off while items keep coming, so the input stalls
  task automatic test_result_backlog();
    snd_idle_pct = 0;
    hold_reqs <= hold_reqs + 1;
    repeat (8)
      offer_event(build_event(rand_ts(), rand_key(),
                              ($urandom_range(1) != 0) ? MODE_ADD : MODE_OTHER,
                              rand_capacity(), rand_capacity()));
  endtask

  task automatic test_sender_pause();
    evt_bus.valid <= 1'b0;
    while (pending_totals_q.size() != 0) @(posedge clk_i);
    offer_event(build_event(rand_ts(), rand_key(), MODE_OTHER, rand_capacity(),
                            rand_capacity()));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      hold_served   <= 0;
      hold_left     <= 0;
    end else if (hold_served != hold_reqs) begin
      hold_served   <= hold_reqs;
      hold_left     <= LONG_HOLD;
      res_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    totals_t seen;
    totals_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      seen = {res_bus.out_timestamp, res_bus.cpu_total, res_bus.mem_total,
              res_bus.table_full};
      if (pending_totals_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: ts %0d cpu %0d mem %0d full %0b", seen.ts,
                   $signed(seen.cpu_total), $signed(seen.mem_total), seen.full);
        mismatch_cnt++;
      end else begin
        want = pending_totals_q.pop_front();
        if (seen.ts !== want.ts || seen.cpu_total !== want.cpu_total ||
            seen.mem_total !== want.mem_total || seen.full !== want.full) begin
          if (mismatch_cnt < 10)
            $display("result differs: ts %0d/%0d cpu %0d/%0d mem %0d/%0d full %0b/%0b",
                     want.ts, seen.ts, $signed(want.cpu_total), $signed(seen.cpu_total),
                     $signed(want.mem_total), $signed(seen.mem_total), want.full,
                     seen.full);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("keyed_resource_capacity_accounting: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    evt_bus.valid        <= 1'b0;
    evt_bus.timestamp    <= '0;
    evt_bus.host_id      <= '0;
    evt_bus.mode         <= MODE_OTHER;
    evt_bus.cpu_capacity <= '0;
    evt_bus.mem_capacity <= '0;
    cpu_acc = 0;
    mem_acc = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_modes();
    test_table_full();
    test_table_drain();
    test_random_mix(330, 21, 62);
    test_random_mix(330, 62, 21);
    test_result_backlog();
    test_sender_pause();
    test_random_mix(330, 0, 0);

    evt_bus.valid <= 1'b0;
    while (pending_totals_q.size() != 0) @(posedge clk_i);
    repeat (TBL + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("keyed_resource_capacity_accounting: match");
    end else begin
      $display("keyed_resource_capacity_accounting: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/krca_pkg.sv
rtl/krca_evt_if.sv
rtl/krca_res_if.sv
rtl/krca_ctrl.sv
rtl/krca_dp.sv
rtl/keyed_resource_capacity_accounting.sv
verif/keyed_resource_capacity_accounting_tb.sv
